>>> rtl/gasp_pkg.sv
// Package for the grid A* path solver.
// Holds the shared constants, the controller command codes and the status struct.
// No dependencies.
package gasp_pkg;

	localparam int GRID_DEF = 16;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SOLVE  = 2'd1;
	localparam logic [1:0] OP_POP    = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] CFG_START_ROW = 2'd0;
	localparam logic [1:0] CFG_GOAL_ROW  = 2'd1;

	localparam logic [2:0] NO_PARENT = 3'd4;

	localparam logic [5:0] ENTRY_COL = 6'h3F;

	typedef enum logic [4:0] {
		C_NONE,
		C_WIPE,
		C_WRITE,
		C_NOP,
		C_POPRD,
		C_POPOUT,
		C_SOLVE_INIT,
		C_CLR,
		C_FAIL,
		C_SEED,
		C_SCAN_START,
		C_SCAN_A,
		C_SCAN_B,
		C_SCAN_C,
		C_PICK,
		C_SHIFT_A,
		C_SHIFT_B,
		C_CLOSE,
		C_COSTLD,
		C_DIRNEXT,
		C_NBRD,
		C_NBUPD,
		C_BLD_A,
		C_BLD_B
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic scan_last;
		logic at_goal;
		logic shift_more;
		logic nb_out;
		logic d_last;
		logic bld_end;
		logic clr_last;
		logic rows_bad;
	} sts_t;

endpackage

>>> rtl/gasp_ctrl.sv
// Controller state machine of the grid A* path solver.
// Sequences wipe, clear, search, path build and pop steps; depends on gasp_pkg.
module gasp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        operation,
	input  gasp_pkg::sts_t    sts,
	output gasp_pkg::cmd_t    cmd,
	output logic              busy
);
	import gasp_pkg::*;

	typedef enum logic [16:0] {
		ST_WIPE    = 17'h00001,
		ST_IDLE    = 17'h00002,
		ST_POP     = 17'h00004,
		ST_CLR     = 17'h00008,
		ST_SEED    = 17'h00010,
		ST_LOOP    = 17'h00020,
		ST_SCAN_A  = 17'h00040,
		ST_SCAN_B  = 17'h00080,
		ST_SCAN_C  = 17'h00100,
		ST_PICK    = 17'h00200,
		ST_SHIFT_A = 17'h00400,
		ST_SHIFT_B = 17'h00800,
		ST_COST    = 17'h01000,
		ST_NB_A    = 17'h02000,
		ST_NB_B    = 17'h04000,
		ST_BLD_A   = 17'h08000,
		ST_BLD_B   = 17'h10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = C_NONE;
		case (state_q)
			ST_WIPE: begin
				cmd = C_WIPE;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (operation)
						OP_WRITE: cmd = C_WRITE;
						OP_SOLVE: begin
							cmd     = C_SOLVE_INIT;
							state_d = ST_CLR;
						end
						OP_POP: begin
							cmd     = C_POPRD;
							state_d = ST_POP;
						end
						default: cmd = C_NOP;
					endcase
				end
			end
			ST_POP: begin
				cmd     = C_POPOUT;
				state_d = ST_IDLE;
			end
			ST_CLR: begin
				cmd = C_CLR;
				if (sts.clr_last) state_d = ST_SEED;
			end
			ST_SEED: begin
				if (sts.rows_bad) begin
					cmd     = C_FAIL;
					state_d = ST_IDLE;
				end else begin
					cmd     = C_SEED;
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.cnt_zero) begin
					cmd     = C_FAIL;
					state_d = ST_IDLE;
				end else begin
					cmd     = C_SCAN_START;
					state_d = ST_SCAN_A;
				end
			end
			ST_SCAN_A: begin
				cmd     = C_SCAN_A;
				state_d = ST_SCAN_B;
			end
			ST_SCAN_B: begin
				cmd     = C_SCAN_B;
				state_d = ST_SCAN_C;
			end
			ST_SCAN_C: begin
				cmd     = C_SCAN_C;
				state_d = sts.scan_last ? ST_PICK : ST_SCAN_A;
			end
			ST_PICK: begin
				cmd     = C_PICK;
				state_d = sts.at_goal ? ST_BLD_A : ST_SHIFT_A;
			end
			ST_SHIFT_A: begin
				if (sts.shift_more) begin
					cmd     = C_SHIFT_A;
					state_d = ST_SHIFT_B;
				end else begin
					cmd     = C_CLOSE;
					state_d = ST_COST;
				end
			end
			ST_SHIFT_B: begin
				cmd     = C_SHIFT_B;
				state_d = ST_SHIFT_A;
			end
			ST_COST: begin
				cmd     = C_COSTLD;
				state_d = ST_NB_A;
			end
			ST_NB_A: begin
				if (sts.nb_out) begin
					cmd     = C_DIRNEXT;
					state_d = sts.d_last ? ST_LOOP : ST_NB_A;
				end else begin
					cmd     = C_NBRD;
					state_d = ST_NB_B;
				end
			end
			ST_NB_B: begin
				cmd     = C_NBUPD;
				state_d = sts.d_last ? ST_LOOP : ST_NB_A;
			end
			ST_BLD_A: begin
				cmd     = C_BLD_A;
				state_d = ST_BLD_B;
			end
			ST_BLD_B: begin
				cmd     = C_BLD_B;
				state_d = sts.bld_end ? ST_IDLE : ST_BLD_A;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/gasp_dp.sv
// Datapath of the grid A* path solver.
// Holds the map, node, open list and path memories, registers and results; depends on gasp_pkg.
module gasp_dp #(
	parameter int GRID = gasp_pkg::GRID_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gasp_pkg::cmd_t    cmd,
	output gasp_pkg::sts_t    sts,
	input  logic [3:0]        cell_col,
	input  logic [3:0]        cell_row,
	input  logic              is_wall,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	output logic              done,
	output logic              point_valid,
	output logic signed [5:0] point_col,
	output logic [3:0]        point_row,
	output logic              solved
);
	import gasp_pkg::*;

	localparam int RW    = $clog2(GRID);
	localparam int IW    = 2 * RW;
	localparam int DEPTH = 1 << IW;
	localparam int CELLS = GRID * GRID;
	localparam int NW    = $clog2(CELLS + 1);
	localparam int LW    = $clog2(CELLS + 3);
	localparam int EW    = $clog2(CELLS + 2 * GRID);

	logic [0:0]    wall_mem [DEPTH];
	logic [1:0]    node_mem [DEPTH];
	logic [EW-1:0] cost_mem [DEPTH];
	logic [EW-1:0] est_mem  [DEPTH];
	logic [2:0]    par_mem  [DEPTH];
	logic [IW-1:0] open_mem [DEPTH];
	logic [IW-1:0] walk_mem [DEPTH];

	logic [0:0]    wall_rd;
	logic [1:0]    node_rd;
	logic [EW-1:0] cost_rd, est_rd;
	logic [2:0]    par_rd;
	logic [IW-1:0] open_rd, walk_rd;

	logic [3:0]    start_row_q, goal_row_q, ent_row_q, ext_row_q;
	logic [RW-1:0] sr_q, gr_q;
	logic [IW-1:0] clr_q;
	logic [NW-1:0] cnt_q, k_q, best_q, bld_n_q;
	logic [EW-1:0] best_est_q, cur_cost_q;
	logic [IW-1:0] best_node_q, scan_node_q, cur_q, bld_c_q;
	logic [1:0]    d_q;
	logic [LW-1:0] len_q, pp_q;
	logic          solved_q, done_q, pv_q;
	logic [5:0]    pc_q;
	logic [3:0]    pr_q;

	logic [6:0]    col_x, row_x, srow_x, grow_x;
	logic          in_grid;
	logic [IW-1:0] wr_cell, start_cell, goal_cell, nb_cell, pred_cell;
	logic [RW-1:0] cur_r, cur_c, nb_r, nb_c, bc_r, bc_c;
	logic [NW-1:0] kp1;
	logic [EW-1:0] nc, heur, dy;
	logic          upd, app, pred_out, nb_out;
	logic [LW-1:0] walk_idx;
	logic          wall_we, node_we, ce_we, par_we, open_we, walk_we;
	logic [IW-1:0] wall_wa, node_wa, ce_wa, par_wa, open_wa, open_ra, cost_ra;
	logic [0:0]    wall_wd;
	logic [1:0]    node_wd;
	logic [EW-1:0] cost_wd, est_wd;
	logic [2:0]    par_wd;
	logic [IW-1:0] open_wd;

	assign col_x      = 7'(cell_col);
	assign row_x      = 7'(cell_row);
	assign srow_x     = 7'(start_row_q);
	assign grow_x     = 7'(goal_row_q);
	assign in_grid    = (col_x < 7'(GRID)) && (row_x < 7'(GRID));
	assign wr_cell    = {row_x[RW-1:0], col_x[RW-1:0]};
	assign start_cell = {sr_q, RW'(0)};
	assign goal_cell  = {gr_q, RW'(GRID - 1)};

	assign cur_r = cur_q[IW-1:RW];
	assign cur_c = cur_q[RW-1:0];
	always_comb begin
		nb_r = cur_r;
		nb_c = cur_c;
		nb_out = 1'b0;
		case (d_q)
			2'd0: begin
				nb_r = cur_r + RW'(1);
				nb_out = (cur_r == RW'(GRID - 1));
			end
			2'd1: begin
				nb_c = cur_c + RW'(1);
				nb_out = (cur_c == RW'(GRID - 1));
			end
			2'd2: begin
				nb_r = cur_r - RW'(1);
				nb_out = (cur_r == RW'(0));
			end
			default: begin
				nb_c = cur_c - RW'(1);
				nb_out = (cur_c == RW'(0));
			end
		endcase
	end
	assign nb_cell = {nb_r, nb_c};

	assign bc_r = bld_c_q[IW-1:RW];
	assign bc_c = bld_c_q[RW-1:0];
	always_comb begin
		pred_cell = bld_c_q;
		pred_out  = 1'b0;
		case (par_rd[1:0])
			2'd0: begin
				pred_cell = {bc_r - RW'(1), bc_c};
				pred_out  = (bc_r == RW'(0));
			end
			2'd1: begin
				pred_cell = {bc_r, bc_c - RW'(1)};
				pred_out  = (bc_c == RW'(0));
			end
			2'd2: begin
				pred_cell = {bc_r + RW'(1), bc_c};
				pred_out  = (bc_r == RW'(GRID - 1));
			end
			default: begin
				pred_cell = {bc_r, bc_c + RW'(1)};
				pred_out  = (bc_c == RW'(GRID - 1));
			end
		endcase
	end

	assign kp1  = k_q + NW'(1);
	assign nc   = cur_cost_q + EW'(1);
	assign dy   = (nb_r > gr_q) ? EW'(nb_r - gr_q) : EW'(gr_q - nb_r);
	assign heur = EW'(RW'(GRID - 1) - nb_c) + dy;
	assign upd  = !wall_rd[0] && (!node_rd[1] || (cost_rd > nc));
	assign app  = upd && (!node_rd[1] || node_rd[0]) && (cnt_q < NW'(CELLS));
	assign walk_idx = len_q - LW'(2) - pp_q;

	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.scan_last  = (kp1 == cnt_q);
	assign sts.at_goal    = (best_node_q == goal_cell);
	assign sts.shift_more = (kp1 < cnt_q);
	assign sts.nb_out     = nb_out;
	assign sts.d_last     = (d_q == 2'd3);
	assign sts.bld_end    = par_rd[2] || pred_out || (bld_n_q == NW'(CELLS));
	assign sts.clr_last   = &clr_q;
	assign sts.rows_bad   = (srow_x >= 7'(GRID)) || (grow_x >= 7'(GRID));

	always_comb begin
		wall_we = 1'b0; wall_wa = clr_q; wall_wd = 1'b1;
		node_we = 1'b0; node_wa = clr_q; node_wd = 2'b00;
		ce_we   = 1'b0; ce_wa = nb_cell; cost_wd = nc; est_wd = nc + heur;
		par_we  = 1'b0; par_wa = nb_cell; par_wd = {1'b0, d_q};
		open_we = 1'b0; open_wa = cnt_q[IW-1:0]; open_wd = nb_cell;
		walk_we = 1'b0;
		cost_ra = nb_cell;
		open_ra = k_q[IW-1:0];
		case (cmd)
			C_WIPE: wall_we = 1'b1;
			C_WRITE: begin
				wall_we = in_grid;
				wall_wa = wr_cell;
				wall_wd = is_wall;
			end
			C_CLR: node_we = 1'b1;
			C_SEED: begin
				node_we = 1'b1; node_wa = start_cell; node_wd = 2'b10;
				ce_we   = 1'b1; ce_wa = start_cell; cost_wd = '0; est_wd = '0;
				par_we  = 1'b1; par_wa = start_cell; par_wd = NO_PARENT;
				open_we = 1'b1; open_wa = '0; open_wd = start_cell;
			end
			C_SHIFT_A: open_ra = kp1[IW-1:0];
			C_SHIFT_B: begin
				open_we = 1'b1; open_wa = k_q[IW-1:0]; open_wd = open_rd;
			end
			C_CLOSE: begin
				node_we = 1'b1; node_wa = cur_q; node_wd = 2'b11;
				cost_ra = cur_q;
			end
			C_NBUPD: begin
				node_we = upd; node_wa = nb_cell; node_wd = 2'b10;
				ce_we   = upd;
				par_we  = upd;
				open_we = app;
			end
			C_BLD_A: walk_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wall_we) wall_mem[wall_wa] <= wall_wd;
		wall_rd <= wall_mem[nb_cell];
	end
	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_wa] <= node_wd;
		node_rd <= node_mem[nb_cell];
	end
	always_ff @(posedge clk) begin
		if (ce_we) cost_mem[ce_wa] <= cost_wd;
		cost_rd <= cost_mem[cost_ra];
	end
	always_ff @(posedge clk) begin
		if (ce_we) est_mem[ce_wa] <= est_wd;
		est_rd <= est_mem[open_rd];
	end
	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_wa] <= par_wd;
		par_rd <= par_mem[bld_c_q];
	end
	always_ff @(posedge clk) begin
		if (open_we) open_mem[open_wa] <= open_wd;
		open_rd <= open_mem[open_ra];
	end
	always_ff @(posedge clk) begin
		if (walk_we) walk_mem[bld_n_q[IW-1:0]] <= bld_c_q;
		walk_rd <= walk_mem[walk_idx[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= '0;
			goal_row_q  <= '0;
			clr_q       <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			pp_q        <= '0;
			solved_q    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_ROW: start_row_q <= cfg_data;
					CFG_GOAL_ROW:  goal_row_q  <= cfg_data;
					default: ;
				endcase
			end
			done_q <= 1'b0;
			case (cmd)
				C_WIPE, C_CLR: clr_q <= clr_q + IW'(1);
				C_WRITE: begin
					done_q <= 1'b1;
					if (in_grid) solved_q <= 1'b0;
				end
				C_NOP, C_FAIL: done_q <= 1'b1;
				C_POPOUT: begin
					done_q <= 1'b1;
					if (solved_q && (pp_q < len_q)) pp_q <= pp_q + LW'(1);
				end
				C_SOLVE_INIT: begin
					solved_q <= 1'b0;
					len_q    <= '0;
					pp_q     <= '0;
					cnt_q    <= '0;
					clr_q    <= '0;
				end
				C_SEED: cnt_q <= NW'(1);
				C_CLOSE: cnt_q <= cnt_q - NW'(1);
				C_NBUPD: if (app) cnt_q <= cnt_q + NW'(1);
				C_BLD_B: begin
					if (sts.bld_end) begin
						done_q   <= 1'b1;
						solved_q <= 1'b1;
						len_q    <= LW'(bld_n_q) + LW'(2);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			C_WRITE, C_NOP, C_FAIL, C_BLD_B: begin
				pv_q <= 1'b0;
				pc_q <= '0;
				pr_q <= '0;
			end
			C_POPOUT: begin
				pv_q <= 1'b0;
				pc_q <= '0;
				pr_q <= '0;
				if (solved_q && (pp_q < len_q)) begin
					pv_q <= 1'b1;
					if (pp_q == '0) begin
						pc_q <= ENTRY_COL;
						pr_q <= ent_row_q;
					end else if (pp_q == len_q - LW'(1)) begin
						pc_q <= 6'(GRID);
						pr_q <= ext_row_q;
					end else begin
						pc_q <= 6'(walk_rd[RW-1:0]);
						pr_q <= 4'(walk_rd[IW-1:RW]);
					end
				end
			end
			C_SOLVE_INIT: begin
				sr_q      <= srow_x[RW-1:0];
				gr_q      <= grow_x[RW-1:0];
				ent_row_q <= start_row_q;
				ext_row_q <= goal_row_q;
			end
			C_SCAN_START: k_q <= '0;
			C_SCAN_B: scan_node_q <= open_rd;
			C_SCAN_C: begin
				if ((k_q == '0) || (est_rd < best_est_q)) begin
					best_q      <= k_q;
					best_est_q  <= est_rd;
					best_node_q <= scan_node_q;
				end
				k_q <= kp1;
			end
			C_PICK: begin
				cur_q   <= best_node_q;
				k_q     <= best_q;
				bld_c_q <= best_node_q;
				bld_n_q <= '0;
			end
			C_SHIFT_B: k_q <= kp1;
			C_COSTLD: begin
				cur_cost_q <= cost_rd;
				d_q        <= 2'd0;
			end
			C_DIRNEXT, C_NBUPD: d_q <= d_q + 2'd1;
			C_BLD_A: bld_n_q <= bld_n_q + NW'(1);
			default: ;
		endcase
		if ((cmd == C_BLD_B) && !sts.bld_end) bld_c_q <= pred_cell;
	end

	assign done        = done_q;
	assign point_valid = pv_q;
	assign point_col   = pc_q;
	assign point_row   = pr_q;
	assign solved      = solved_q;

endmodule

>>> rtl/grid_astar_path_solver_top.sv
// Top level of the grid A* path solver.
// Joins the controller gasp_ctrl and the datapath gasp_dp; depends on gasp_pkg.
//
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               operation, cell_col, cell_row, is_wall
// result    out        done (one-cycle strobe)   point_valid, point_col, point_row, solved
// config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// A cell write or an unused operation is done from the idle state; a pop also passes
// ST_POP for the registered read of the path memory. A solve first clears the node
// memory, one entry per cycle over all 2**(2*clog2(GRID)) entries, then per expansion
// scans the open list for the minimum (ST_SCAN_A/B/C), shifts the later entries down
// (ST_SHIFT_A/B), visits the neighbors (ST_NB_A/B) and builds the path (ST_BLD_A/B).
// After reset the wall map is set to walls likewise, busy high. Results cannot stall.
module grid_astar_path_solver_top #(
	parameter int GRID = gasp_pkg::GRID_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        operation,
	input  logic [3:0]        cell_col,
	input  logic [3:0]        cell_row,
	input  logic              is_wall,
	output logic              done,
	output logic              point_valid,
	output logic signed [5:0] point_col,
	output logic [3:0]        point_row,
	output logic              solved,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data
);
	import gasp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	gasp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	gasp_dp #(
		.GRID (GRID)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.is_wall     (is_wall),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.point_valid (point_valid),
		.point_col   (point_col),
		.point_row   (point_row),
		.solved      (solved)
	);

endmodule

>>> bench/tb.sv
// Testbench for the grid A* path solver: writes wall maps, solves and pops paths,
// and compares every result with an A* predictor kept inside this file.
// Depends on gasp_pkg and grid_astar_path_solver_top.
`timescale 1ns / 100ps

module tb;
	import gasp_pkg::*;

	localparam int GRID = GRID_DEF;
	localparam int CELLS = GRID * GRID;
	localparam int LIMIT = 40000000;

	typedef struct packed {
		logic       pv;
		logic [5:0] pc;
		logic [3:0] pr;
		logic       sv;
	} point_t;

	logic clk = 0, arst_n = 0, start = 0, is_wall = 0, cfg_valid = 0;
	logic [1:0] operation = OP_WRITE, cfg_index = CFG_START_ROW;
	logic [3:0] cell_col = 0, cell_row = 0, cfg_data = 0;
	logic busy, done, point_valid, solved, cfg_ready;
	logic signed [5:0] point_col;
	logic [3:0] point_row;

	grid_astar_path_solver_top #(.GRID(GRID)) DUT (.*);

	// Predictor state.
	logic [3:0] m_start, m_goal;
	bit wall_m[CELLS];
	int g_cost[CELLS], f_cost[CELLS], par[CELLS], open_q[CELLS];
	bit known[CELLS], closed[CELLS];
	int open_n, path_len, pop_ix;
	bit solved_m;
	logic [5:0] path_c[CELLS + 2];
	logic [3:0] path_r[CELLS + 2];

	point_t pending_points[$];
	int errors = 0, results_seen = 0, items_sent = 0, paths_found = 0;
	int send_idle = 0;
	longint cycles = 0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int manhattan(int x, int y);
		int dy;
		dy = (y > m_goal) ? y - m_goal : m_goal - y;
		return (GRID - 1 - x) + dy;
	endfunction

	function automatic void trace_path(int goal);
		int chain[CELLS];
		int c, d, px, py, n;
		c = goal;
		n = 0;
		while (n < CELLS) begin
			chain[n] = c;
			n++;
			d = par[c];
			if (d >= NO_PARENT) break;
			px = c % GRID - ((d == 1) ? 1 : (d == 3) ? -1 : 0);
			py = c / GRID - ((d == 0) ? 1 : (d == 2) ? -1 : 0);
			if (px < 0 || px >= GRID || py < 0 || py >= GRID) break;
			c = py * GRID + px;
		end
		path_c[0] = ENTRY_COL;
		path_r[0] = m_start;
		for (int k = 0; k < n; k++) begin
			path_c[k + 1] = 6'(chain[n - 1 - k] % GRID);
			path_r[k + 1] = 4'(chain[n - 1 - k] / GRID);
		end
		path_c[n + 1] = 6'(GRID);
		path_r[n + 1] = m_goal;
		path_len = n + 2;
	endfunction

	function automatic void astar_search();
		int s, goal, best, cur, nx, ny, nb, nc;
		for (int i = 0; i < CELLS; i++) begin
			known[i] = 0;
			closed[i] = 0;
		end
		open_n = 0;
		path_len = 0;
		pop_ix = 0;
		solved_m = 0;
		s = m_start * GRID;
		goal = m_goal * GRID + GRID - 1;
		known[s] = 1;
		g_cost[s] = 0;
		f_cost[s] = 0;
		par[s] = NO_PARENT;
		open_q[0] = s;
		open_n = 1;
		while (open_n != 0) begin
			best = 0;
			for (int k = 1; k < open_n; k++)
				if (f_cost[open_q[k]] < f_cost[open_q[best]]) best = k;
			cur = open_q[best];
			if (cur == goal) begin
				solved_m = 1;
				trace_path(goal);
				return;
			end
			for (int k = best; k + 1 < open_n; k++) open_q[k] = open_q[k + 1];
			open_n--;
			closed[cur] = 1;
			for (int d = 0; d < 4; d++) begin
				nx = cur % GRID + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
				ny = cur / GRID + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
				if (nx < 0 || nx >= GRID || ny < 0 || ny >= GRID) continue;
				nb = ny * GRID + nx;
				if (wall_m[nb]) continue;
				nc = g_cost[cur] + 1;
				if (known[nb]) begin
					if (g_cost[nb] <= nc) continue;
					if (closed[nb]) begin
						closed[nb] = 0;
						if (open_n < CELLS) open_q[open_n++] = nb;
					end
				end else begin
					known[nb] = 1;
					if (open_n < CELLS) open_q[open_n++] = nb;
				end
				g_cost[nb] = nc;
				f_cost[nb] = nc + manhattan(nx, ny);
				par[nb] = d;
			end
		end
	endfunction

	function automatic point_t predict_point(logic [1:0] op, logic [3:0] c, logic [3:0] r,
			logic w);
		point_t p;
		p = '0;
		if (op == OP_WRITE) begin
			if (c < GRID && r < GRID) begin
				wall_m[r * GRID + c] = w;
				solved_m = 0;
			end
		end else if (op == OP_SOLVE) begin
			astar_search();
			if (solved_m) paths_found++;
		end else if (op == OP_POP) begin
			if (solved_m && pop_ix < path_len) begin
				p.pv = 1;
				p.pc = path_c[pop_ix];
				p.pr = path_r[pop_ix];
				pop_ix++;
			end
		end
		p.sv = solved_m;
		return p;
	endfunction

	always @(posedge clk) begin
		point_t e;
		if (done) begin
			results_seen++;
			if (pending_points.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result at cycle %0d", cycles);
			end else begin
				e = pending_points[0];
				pending_points.delete(0);
				if (point_valid !== e.pv || point_col !== e.pc || point_row !== e.pr
						|| solved !== e.sv) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch: expected v%0d c%0d r%0d s%0d, got v%0d c%0d r%0d s%0d",
							e.pv, $signed(e.pc), e.pr, e.sv, point_valid, point_col,
							point_row, solved);
				end
			end
		end
	end

	// The item is taken at the first rising edge that finds busy low.
	task automatic send_item(logic [1:0] op, logic [3:0] c, logic [3:0] r, logic w);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			start <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		start <= 1;
		operation <= op;
		cell_col <= c;
		cell_row <= r;
		is_wall <= w;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_points.insert(pending_points.size(), predict_point(op, c, r, w));
		items_sent++;
	endtask

	task automatic wait_drained();
		start <= 0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [3:0] val);
		wait_drained();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_START_ROW) m_start = val;
		else m_goal = val;
	endtask

	task automatic pop_all();
		for (int i = 0; i < GRID * 2 + 4; i++) send_item(OP_POP, 4'd0, 4'd0, 1'b0);
	endtask

	// Open one row as a corridor, then write either the whole map or a number of
	// random cells, each open with the given percentage.
	task automatic load_map(int open_pct, int corridor, int n_rand);
		if (n_rand == 0) begin
			for (int r = 0; r < GRID; r++)
				for (int c = 0; c < GRID; c++)
					send_item(OP_WRITE, 4'(c), 4'(r),
						(r == corridor) ? 1'b0 : ($urandom_range(99) >= open_pct));
		end else begin
			for (int c = 0; c < GRID; c++) send_item(OP_WRITE, 4'(c), 4'(corridor), 1'b0);
			for (int i = 0; i < n_rand; i++)
				send_item(OP_WRITE, 4'($urandom_range(GRID - 1)),
					4'($urandom_range(GRID - 1)), ($urandom_range(99) >= open_pct));
		end
	endtask

	task automatic test_directed();
		send_item(OP_POP, 4'd0, 4'd0, 1'b0);
		send_item(OP_SOLVE, 4'd0, 4'd0, 1'b0);
		send_item(OP_UNUSED, 4'hF, 4'hF, 1'b1);
		for (int c = 0; c < GRID; c++) send_item(OP_WRITE, 4'(c), 4'd0, 1'b0);
		send_item(OP_WRITE, 4'd0, 4'd0, 1'b1);
		send_item(OP_SOLVE, 4'hF, 4'hF, 1'b1);
		send_item(OP_POP, 4'd0, 4'd0, 1'b0);
		send_item(OP_POP, 4'd0, 4'd0, 1'b0);
		send_item(OP_WRITE, 4'd5, 4'd0, 1'b0);
		send_item(OP_POP, 4'd0, 4'd0, 1'b0);
	endtask

	task automatic test_solve_round(int open_pct, int n_rand);
		int row;
		row = $urandom_range(GRID - 1);
		write_register(CFG_START_ROW, 4'($urandom_range(GRID - 1)));
		write_register(CFG_GOAL_ROW, 4'($urandom_range(GRID - 1)));
		load_map(open_pct, row, n_rand);
		send_item(OP_SOLVE, 4'($urandom), 4'($urandom), 1'($urandom));
		pop_all();
		if ($urandom_range(3) == 0) begin
			send_item(OP_WRITE, 4'($urandom), 4'($urandom), 1'($urandom));
			send_item(OP_POP, 4'($urandom), 4'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_noise(int n);
		for (int i = 0; i < n; i++)
			send_item(2'($urandom_range(3)), 4'($urandom), 4'($urandom), 1'($urandom));
	endtask

	initial begin
		m_start = 0;
		m_goal = 0;
		for (int i = 0; i < CELLS; i++) wall_m[i] = 1;
		solved_m = 0;
		path_len = 0;
		pop_ix = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		write_register(CFG_START_ROW, 4'hF);
		write_register(CFG_GOAL_ROW, 4'hF);
		test_solve_round(100, 0);
		write_register(CFG_START_ROW, 4'd0);
		write_register(CFG_GOAL_ROW, 4'd0);
		send_idle = 66;
		test_noise(20);
		wait_drained();
		send_idle = 28;
		test_solve_round(85, 48);
		send_idle = 0;
		test_solve_round(70, 48);
		test_noise(30);
		wait_drained();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d solves reached the goal.",
			items_sent, results_seen, paths_found);
		if (errors == 0 && pending_points.size() == 0)
			$display("Test completed successfully");
		else begin
			$display("%0d mismatches, %0d results missing", errors, pending_points.size());
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

>>> grid_astar_path_solver_top.f
rtl/gasp_pkg.sv
rtl/gasp_ctrl.sv
rtl/gasp_dp.sv
rtl/grid_astar_path_solver_top.sv
bench/tb.sv
